### hw/rtl/hcfa_pkg.sv
// Shared types and constants for the formaldehyde sensor frame averager.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hcfa_pkg;

  // Default number of good frames per emitted average
  localparam int unsigned AverageCountDefault = 4;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned AccW   = 18;
  localparam int unsigned StatW  = 3;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  // Frame offsets of the byte expected next
  localparam logic [PosW-1:0] PosHunt   = 4'd0;
  localparam logic [PosW-1:0] PosCmd    = 4'd1;
  localparam logic [PosW-1:0] PosUnit   = 4'd2;
  localparam logic [PosW-1:0] PosConcHi = 4'd4;
  localparam logic [PosW-1:0] PosConcLo = 4'd5;
  localparam logic [PosW-1:0] PosFsHi   = 4'd6;
  localparam logic [PosW-1:0] PosFsLo   = 4'd7;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHdrPrimary   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHdrAlternate = 8'd1;
  localparam logic [CfgIdxW-1:0] RegCommandCode  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegUnitCode     = 8'd3;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0] HdrPrimaryRst   = 8'hFF;
  localparam logic [ByteW-1:0] HdrAlternateRst = 8'hFF;
  localparam logic [ByteW-1:0] CommandCodeRst  = 8'h17;
  localparam logic [ByteW-1:0] UnitCodeRst     = 8'h04;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_CMD  = 2'd1,
    FAULT_UNIT = 2'd2
  } fault_e;

  typedef enum logic [StatW-1:0] {
    ST_AVERAGE = 3'd0,
    ST_CKSUM   = 3'd1,
    ST_CMD     = 3'd2,
    ST_UNIT    = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] hdr_primary;
    logic [ByteW-1:0] hdr_alternate;
    logic [ByteW-1:0] command_code;
    logic [ByteW-1:0] unit_code;
  } cfg_t;

  // Judgement of one complete frame, handed from parser to averager
  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] conc;
  } verdict_t;

endpackage

`default_nettype wire

### hw/rtl/hcfa_cfg_regs.sv
// Configuration register file of the frame averager.
// Depends on hcfa_pkg.
`default_nettype none

module hcfa_cfg_regs
  import hcfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_index_i)
        RegHdrPrimary:   cfg_d.hdr_primary   = cfg_data_i;
        RegHdrAlternate: cfg_d.hdr_alternate = cfg_data_i;
        RegCommandCode:  cfg_d.command_code  = cfg_data_i;
        RegUnitCode:     cfg_d.unit_code     = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_primary   <= HdrPrimaryRst;
      cfg_q.hdr_alternate <= HdrAlternateRst;
      cfg_q.command_code  <= CommandCodeRst;
      cfg_q.unit_code     <= UnitCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/hcfa_parser.sv
// Frame parser: header hunt, field capture, checksum and frame judgement.
// Holds one registered verdict word. Depends on hcfa_pkg.
`default_nettype none

module hcfa_parser
  import hcfa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [ByteW-1:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire logic             adv_i,          // averager takes the verdict
  output logic                  vld_o,
  output verdict_t              verdict_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] cksum_q, cksum_d;
  fault_e           fault_q, fault_d;
  logic [WordW-1:0] conc_q, conc_d;
  logic [WordW-1:0] fs_q, fs_d;
  logic             vld_q, vld_d;
  verdict_t         verdict_q, verdict_d;
  logic             accept;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] cksum_sum;

  assign s_axis_tready = !vld_q || adv_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign cksum_sum     = cksum_q + b;

  // Byte sequencing and judgement
  always_comb begin
    pos_d     = pos_q;
    cksum_d   = cksum_q;
    fault_d   = fault_q;
    conc_d    = conc_q;
    fs_d      = fs_q;
    vld_d     = vld_q && !adv_i;
    verdict_d = verdict_q;
    if (accept) begin
      if (pos_q == PosHunt) begin
        if (b == cfg_i.hdr_primary || b == cfg_i.hdr_alternate) begin
          pos_d   = PosCmd;
          cksum_d = '0;
          fault_d = FAULT_NONE;
          conc_d  = '0;
          fs_d    = '0;
        end
      end else if (pos_q <= PosFsLo) begin
        cksum_d = cksum_sum;
        pos_d   = pos_q + PosW'(1);
        case (pos_q)
          PosCmd:    if (b != cfg_i.command_code) fault_d = FAULT_CMD;
          PosUnit:   if (b != cfg_i.unit_code && fault_q == FAULT_NONE) fault_d = FAULT_UNIT;
          PosConcHi: conc_d = {b, ByteW'(0)};
          PosConcLo: conc_d = {conc_q[WordW-1:ByteW], b};
          PosFsHi:   fs_d   = {b, ByteW'(0)};
          PosFsLo:   fs_d   = {fs_q[WordW-1:ByteW], b};
          default:   ;
        endcase
      end else begin
        // Checksum byte: byte sum over offsets one to eight must wrap to zero
        pos_d          = PosHunt;
        vld_d          = 1'b1;
        verdict_d.conc = conc_q;
        if (cksum_sum != '0)             verdict_d.status = ST_CKSUM;
        else if (fault_q == FAULT_CMD)   verdict_d.status = ST_CMD;
        else if (fault_q == FAULT_UNIT)  verdict_d.status = ST_UNIT;
        else if (conc_q > fs_q)          verdict_d.status = ST_RANGE;
        else                             verdict_d.status = ST_AVERAGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      fault_q <= FAULT_NONE;
      vld_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      fault_q <= fault_d;
      vld_q   <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    cksum_q   <= cksum_d;
    conc_q    <= conc_d;
    fs_q      <= fs_d;
    verdict_q <= verdict_d;
  end

  assign vld_o     = vld_q;
  assign verdict_o = verdict_q;

endmodule

`default_nettype wire

### hw/rtl/hcfa_averager.sv
// Averager: saturating sum of good concentrations and the result register.
// Depends on hcfa_pkg.
`default_nettype none

module hcfa_averager
  import hcfa_pkg::*;
#(
  parameter int unsigned AVERAGE_COUNT = AverageCountDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire verdict_t         verdict_i,
  output logic                  adv_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [17:0] average_fixed, [23:18] zero
  output logic [StatW-1:0]      m_axis_tuser    // [2:0] status
);

  localparam int unsigned CntW = $clog2(AVERAGE_COUNT) + 1;
  localparam logic [CntW-1:0] CntLast = CntW'(AVERAGE_COUNT);

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_inc;
  logic [AccW:0]   sum;
  logic [AccW-1:0] sum_sat;
  logic            out_v_q, out_v_d;
  status_e         out_st_q, out_st_d;
  logic [AccW-1:0] out_val_q, out_val_d;
  logic            take;

  assign adv_o   = !out_v_q || m_axis_tready;
  assign take    = vld_i && adv_o;
  assign sum     = {1'b0, acc_q} + (AccW+1)'(verdict_i.conc);
  assign sum_sat = sum[AccW] ? AccMax : sum[AccW-1:0];
  assign cnt_inc = cnt_q + CntW'(1);

  // Accumulate, emit on full count or on any error
  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    out_v_d   = out_v_q && !m_axis_tready;
    out_st_d  = out_st_q;
    out_val_d = out_val_q;
    if (take) begin
      if (verdict_i.status != ST_AVERAGE) begin
        acc_d     = '0;
        cnt_d     = '0;
        out_v_d   = 1'b1;
        out_st_d  = verdict_i.status;
        out_val_d = '0;
      end else if (cnt_inc >= CntLast) begin
        acc_d     = '0;
        cnt_d     = '0;
        out_v_d   = 1'b1;
        out_st_d  = ST_AVERAGE;
        out_val_d = sum_sat;
      end else begin
        acc_d = sum_sat;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q  <= out_st_d;
    out_val_q <= out_val_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {6'd0, out_val_q};

endmodule

`default_nettype wire

### hw/rtl/hcho_sensor_frame_averager_top.sv
// Top level of the formaldehyde sensor frame averager.
// Depends on hcfa_pkg, hcfa_cfg_regs, hcfa_parser and hcfa_averager.
//
//   channel   direction  word                   handshake
//   s_axis    in         tdata[7:0] rx_byte     tvalid/tready
//   m_axis    out        tdata[17:0] average,   tvalid/tready
//                        tuser[2:0] status
//   cfg       in         index[7:0], data[7:0]  cfg_valid_i/cfg_ready_o
//
// One byte is accepted per cycle while s_axis_tready is high. A checksum byte loads
// the verdict register; the averager takes it when its result register is free.
// Reset is asynchronous, active low; config registers return to their defaults.
// Output stalls back up through the verdict register to s_axis_tready; bytes
// that give no result flow on while a result waits, until the verdict stage fills.
`default_nettype none

module hcho_sensor_frame_averager_top
  import hcfa_pkg::*;
#(
  parameter int unsigned AVERAGE_COUNT = AverageCountDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [ByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // [17:0] average_fixed, [23:18] zero
  output logic [StatW-1:0]        m_axis_tuser,   // [2:0] status
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i
);

  cfg_t     cfg;
  logic     vld;
  logic     adv;
  verdict_t verdict;

  hcfa_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  hcfa_parser u_parser (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .adv_i     (adv),
    .vld_o     (vld),
    .verdict_o (verdict)
  );

  hcfa_averager #(
    .AVERAGE_COUNT (AVERAGE_COUNT)
  ) u_avg (
    .clk_i,
    .rst_ni,
    .vld_i     (vld),
    .verdict_i (verdict),
    .adv_o     (adv),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  // Error results carry a zero sum
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_AVERAGE |-> m_axis_tdata == '0)
    else $error("error result with nonzero sum");

  // A waiting verdict is held while the result register is blocked
  a_verdict_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld && !adv |=> vld && $stable(verdict))
    else $error("verdict lost under stall");

  // The parser takes no byte while its verdict cannot move on
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("byte accepted over a blocked verdict");

endmodule

`default_nettype wire

### verif/tb.sv
// Bench for hcho_sensor_frame_averager_top: feeds serial bytes in frames and as noise,
// tracks the expected verdicts and averages in a local copy of the parser and averager.
// Depends on hcfa_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import hcfa_pkg::*;

  localparam int unsigned AvgFrames    = AverageCountDefault;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned PhaseBytes   = 175;
  localparam int unsigned HoldCycles   = 300;

  // Indexes past the last register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegPastLast = RegUnitCode + CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegTop      = {CfgIdxW{1'b1}};

  typedef struct {
    status_e         status;
    logic [AccW-1:0] average;
  } sensor_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata = '0;    // [7:0] rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;         // [17:0] average_fixed, [23:18] zero
  logic [StatW-1:0]   m_axis_tuser;         // [2:0] status
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_data_i = '0;

  hcho_sensor_frame_averager_top #(
    .AVERAGE_COUNT(AvgFrames)
  ) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Predicted results, oldest first
  sensor_result_t pending_results[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  // Local copy of the registers and frame state
  logic [ByteW-1:0] hdr_pri, hdr_alt, cmd_code, unit_code;
  logic [PosW-1:0]  frame_pos;
  logic [ByteW-1:0] frame_sum;
  fault_e           frame_fault;
  logic [WordW-1:0] conc_word, fs_word;
  logic [AccW-1:0]  conc_total;
  int unsigned      good_frames;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_mismatch(input string what, input logic [23:0] want, got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportMax)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    sensor_result_t want_r;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        want_r = pending_results.pop_front();
        if (m_axis_tuser !== want_r.status)
          flag_mismatch("status", 24'(want_r.status), 24'(m_axis_tuser));
        if (m_axis_tdata !== 24'(want_r.average))
          flag_mismatch("average", 24'(want_r.average), m_axis_tdata);
      end
    end
  end

  // Parse one accepted byte and queue the result word it leads to, if any
  task automatic parse_and_average(input logic [ByteW-1:0] b);
    sensor_result_t r;
    logic [AccW:0]  sum;
    logic [ByteW-1:0] want_ck;
    bit             judged;
    if (frame_pos == PosHunt) begin
      if (b == hdr_pri || b == hdr_alt) begin
        frame_pos = PosCmd;
        frame_sum = '0;
        frame_fault = FAULT_NONE;
        conc_word = '0;
        fs_word = '0;
      end
    end else if (frame_pos <= PosFsLo) begin
      frame_sum = frame_sum + b;
      case (frame_pos)
        PosCmd: begin
          if (b != cmd_code) frame_fault = FAULT_CMD;
        end
        PosUnit: begin
          if (b != unit_code && frame_fault == FAULT_NONE) frame_fault = FAULT_UNIT;
        end
        PosConcHi: conc_word = {b, 8'h00};
        PosConcLo: conc_word[7:0] = b;
        PosFsHi:   fs_word = {b, 8'h00};
        PosFsLo:   fs_word[7:0] = b;
        default: ;
      endcase
      frame_pos = frame_pos + PosW'(1);
    end else begin
      // checksum byte: judge the frame
      frame_pos = PosHunt;
      want_ck = 8'h00 - frame_sum;
      judged = 1'b1;
      r.average = '0;
      r.status = ST_AVERAGE;
      if (want_ck != b) r.status = ST_CKSUM;
      else if (frame_fault == FAULT_CMD) r.status = ST_CMD;
      else if (frame_fault == FAULT_UNIT) r.status = ST_UNIT;
      else if (conc_word > fs_word) r.status = ST_RANGE;
      else begin
        sum = conc_total + conc_word;
        conc_total = (sum > AccMax) ? AccMax : sum[AccW-1:0];
        good_frames++;
        judged = 1'b0;
        if (good_frames >= AvgFrames) begin
          r.average = conc_total;
          judged = 1'b1;
        end
      end
      if (judged) begin
        conc_total = '0;
        good_frames = 0;
        pending_results.push_back(r);
      end
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it; valid stays high after
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_and_average(b);
  endtask

  // Build a frame with a correct checksum (unless ck_err flips bits) and send nbytes of it
  task automatic send_frame(input logic [ByteW-1:0] hdr, cmd, unit, spare,
                            input logic [WordW-1:0] conc, fs,
                            input logic [ByteW-1:0] ck_err, input int unsigned nbytes);
    logic [ByteW-1:0] fb [9];
    logic [ByteW-1:0] s;
    fb[0] = hdr;
    fb[1] = cmd;
    fb[2] = unit;
    fb[3] = spare;
    fb[4] = conc[15:8];
    fb[5] = conc[7:0];
    fb[6] = fs[15:8];
    fb[7] = fs[7:0];
    s = '0;
    for (int i = 1; i < 8; i++) s = s + fb[i];
    fb[8] = (8'h00 - s) ^ ck_err;
    for (int i = 0; i < nbytes; i++) send_byte(fb[i]);
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegHdrPrimary:   hdr_pri = val;
      RegHdrAlternate: hdr_alt = val;
      RegCommandCode:  cmd_code = val;
      RegUnitCode:     unit_code = val;
      default: ;
    endcase
  endtask

  // All four registers, plus two writes to unused indexes that must change nothing
  task automatic load_config(input logic [ByteW-1:0] p, a, c, u);
    write_reg(RegHdrPrimary, p);
    write_reg(RegPastLast, 8'($urandom_range(255)));
    write_reg(RegHdrAlternate, a);
    write_reg(RegCommandCode, c);
    write_reg(RegTop, 8'($urandom_range(255)));
    write_reg(RegUnitCode, u);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WordW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Mostly well-formed frames; some noise ahead, a few faults and truncations
  task automatic send_random_frame(output int unsigned nsent);
    logic [ByteW-1:0] hdr, cmd, unit, ck_err, noise;
    logic [WordW-1:0] conc, fs;
    int unsigned roll;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        noise = 8'($urandom_range(255));
        if (noise != hdr_pri && noise != hdr_alt) send_byte(noise);
      end
    end
    hdr = $urandom_range(1) ? hdr_pri : hdr_alt;
    cmd = ($urandom_range(99) < 94) ? cmd_code : 8'($urandom_range(255));
    unit = ($urandom_range(99) < 94) ? unit_code : 8'($urandom_range(255));
    ck_err = ($urandom_range(99) < 94) ? 8'h00 : 8'($urandom_range(1, 255));
    conc = pick_word();
    roll = $urandom_range(99);
    if (roll < 15) fs = conc;
    else if (roll < 88) fs = conc + 16'($urandom_range(32'(16'hFFFF - conc)));
    else fs = pick_word();
    nsent = ($urandom_range(99) < 5) ? $urandom_range(1, 8) : 9;
    send_frame(hdr, cmd, unit, 8'($urandom_range(255)), conc, fs, ck_err, nsent);
  endtask

  // Directed: ignored bytes, each fault kind and the fault order
  task automatic run_frame_faults();
    send_byte(8'h00);
    send_byte(8'hFE);
    // bad checksum wins over a bad command
    send_frame(HdrPrimaryRst, 8'h00, UnitCodeRst, 8'h00, 16'hFFFF, 16'h0000, 8'h01, 9);
    // command and unit both bad report the command
    send_frame(HdrAlternateRst, 8'h18, 8'h05, 8'hAA, 16'h0000, 16'h0000, 8'h00, 9);
    send_frame(HdrPrimaryRst, CommandCodeRst, 8'h00, 8'h55, 16'h0001, 16'h0001, 8'h00, 9);
    send_frame(HdrPrimaryRst, CommandCodeRst, UnitCodeRst, 8'h00, 16'h8000, 16'h7FFF,
               8'h00, 9);
    // equal concentration and full scale is good; stays in the running sum
    send_frame(HdrPrimaryRst, CommandCodeRst, UnitCodeRst, 8'hFF, 16'hFFFF, 16'hFFFF,
               8'h00, 9);
    wait_results_drained();
  endtask

  // Random stream under one register setting, ending on a frame boundary
  task automatic run_random_stream(input logic [ByteW-1:0] p, a, c, u);
    int unsigned sent_bytes;
    int unsigned n;
    sent_bytes = 0;
    load_config(p, a, c, u);
    while (sent_bytes < PhaseBytes) begin
      send_random_frame(n);
      sent_bytes += n;
    end
    while (frame_pos != PosHunt) send_byte(8'($urandom_range(255)));
    wait_results_drained();
  endtask

  // Receiver holds off while failing frames keep coming, so the input backs up
  task automatic run_output_backpressure();
    int unsigned saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    hold_request = HoldCycles;
    repeat (8) begin
      send_frame(hdr_alt, cmd_code, unit_code, 8'($urandom_range(255)), pick_word(),
                 pick_word(), 8'($urandom_range(1, 255)), 9);
    end
    wait_results_drained();
    send_idle_pct = saved_idle;
  endtask

  initial begin
    hdr_pri = HdrPrimaryRst;
    hdr_alt = HdrAlternateRst;
    cmd_code = CommandCodeRst;
    unit_code = UnitCodeRst;
    frame_pos = PosHunt;
    frame_sum = '0;
    frame_fault = FAULT_NONE;
    conc_word = '0;
    fs_word = '0;
    conc_total = '0;
    good_frames = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 7;
    recv_idle_pct = 77;
    run_frame_faults();
    run_random_stream(8'h00, 8'hFF, 8'h00, 8'hFF);
    run_output_backpressure();

    send_idle_pct = 77;
    recv_idle_pct = 7;
    run_random_stream(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_stream(8'hFF, 8'h00, 8'hFF, 8'h00);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/hcfa_pkg.sv
hw/rtl/hcfa_cfg_regs.sv
hw/rtl/hcfa_parser.sv
hw/rtl/hcfa_averager.sv
hw/rtl/hcho_sensor_frame_averager_top.sv
verif/tb.sv
